// ===== hdl/bal_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types, sizes and codes for the bounded array list engine.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 12;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 13;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    MODE_APPEND  = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_POP     = 3'd2,
    MODE_ERASE   = 3'd3,
    MODE_REVERSE = 3'd4,
    MODE_READ    = 3'd5,
    MODE_WRITE   = 3'd6,
    MODE_CLEAR   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                   mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]      count;
    status_t                 status;
  } out_item_t;

  // datapath steps issued by the controller
  typedef enum logic [3:0] {
    STEP_NOP,
    STEP_APPEND,
    STEP_POP,
    STEP_WRITE,
    STEP_CLEAR,
    STEP_REJECT,
    STEP_RD_ISSUE,
    STEP_RD_FIN,
    STEP_INS_START,
    STEP_INS_MOVE,
    STEP_INS_FIN,
    STEP_ERS_START,
    STEP_ERS_MOVE,
    STEP_REV_START,
    STEP_REV_A,
    STEP_REV_B
  } step_t;

  typedef struct packed {
    step_t   step;
    logic    load;
    logic    finish;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic full;
    logic empty;
    logic erase_tail;
    logic rev_short;
    logic ins_last;
    logic ers_last;
    logic rev_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/bal_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bal_dp
// Datapath: entry memory, live count, move pointers and result register.
// ----------------------------------------------------------------------------
module bal_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bal_pkg::in_item_t   in_item,
  input  bal_pkg::cmd_t       cmd,
  output bal_pkg::sts_t       sts,
  output logic                out_valid,
  output bal_pkg::out_item_t  out_item
);

  localparam int AW = bal_pkg::ADDR_W;
  localparam int CW = bal_pkg::CNT_W;
  localparam int MW = bal_pkg::CMP_W;
  localparam int VW = bal_pkg::VAL_W;
  localparam int OW = bal_pkg::COUNT_W;

  logic [VW-1:0]       mem [bal_pkg::CAPACITY];
  logic [VW-1:0]       rdata_r;
  bal_pkg::in_item_t   item_r, item_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic                out_valid_r;
  bal_pkg::out_item_t  out_item_r;

  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [VW-1:0]       wdata;
  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       in_pos_a, item_pos_a;
  logic [AW:0]         rev_gap;

  assign cnt_m1     = cnt_r - CW'(1);
  assign in_pos_a   = AW'(in_item.position);
  assign item_pos_a = AW'(item_r.position);
  assign rev_gap    = {1'b0, hi_r} - {1'b0, ptr_r};

  assign sts.pos_ok     = MW'(in_item.position) < MW'(cnt_r);
  assign sts.full       = cnt_r >= CW'(bal_pkg::CAPACITY);
  assign sts.empty      = cnt_r == '0;
  assign sts.erase_tail = MW'(in_item.position) == MW'(cnt_m1);
  assign sts.rev_short  = cnt_r < CW'(2);
  assign sts.ins_last   = ptr_r == item_pos_a;
  assign sts.ers_last   = ptr_r == AW'(cnt_m1);
  assign sts.rev_last   = rev_gap <= (AW + 1)'(2);

  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    waddr    = ptr_r;
    raddr    = ptr_r;
    wdata    = rdata_r;
    ptr_nxt  = ptr_r;
    hi_nxt   = hi_r;
    cnt_nxt  = cnt_r;
    item_nxt = cmd.load ? in_item : item_r;
    unique case (cmd.step)
      bal_pkg::STEP_NOP,
      bal_pkg::STEP_REJECT,
      bal_pkg::STEP_RD_FIN: begin
      end
      bal_pkg::STEP_APPEND: begin
        we      = 1'b1;
        waddr   = AW'(cnt_r);
        wdata   = in_item.value;
        cnt_nxt = cnt_r + CW'(1);
      end
      bal_pkg::STEP_POP: begin
        cnt_nxt = cnt_m1;
      end
      bal_pkg::STEP_WRITE: begin
        we    = 1'b1;
        waddr = in_pos_a;
        wdata = in_item.value;
      end
      bal_pkg::STEP_CLEAR: begin
        cnt_nxt = '0;
      end
      bal_pkg::STEP_RD_ISSUE: begin
        re    = 1'b1;
        raddr = in_pos_a;
      end
      bal_pkg::STEP_INS_START: begin
        re      = 1'b1;
        raddr   = AW'(cnt_m1);
        ptr_nxt = AW'(cnt_m1);
      end
      bal_pkg::STEP_INS_MOVE: begin
        // move the entry read last cycle one place up, fetch the one below
        we    = 1'b1;
        waddr = ptr_r + AW'(1);
        if (!sts.ins_last) begin
          re      = 1'b1;
          raddr   = ptr_r - AW'(1);
          ptr_nxt = ptr_r - AW'(1);
        end
      end
      bal_pkg::STEP_INS_FIN: begin
        we      = 1'b1;
        waddr   = item_pos_a;
        wdata   = item_r.value;
        cnt_nxt = cnt_r + CW'(1);
      end
      bal_pkg::STEP_ERS_START: begin
        re      = 1'b1;
        raddr   = in_pos_a + AW'(1);
        ptr_nxt = in_pos_a + AW'(1);
      end
      bal_pkg::STEP_ERS_MOVE: begin
        we    = 1'b1;
        waddr = ptr_r - AW'(1);
        if (sts.ers_last) begin
          cnt_nxt = cnt_m1;
        end else begin
          re      = 1'b1;
          raddr   = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      bal_pkg::STEP_REV_START: begin
        re      = 1'b1;
        raddr   = '0;
        ptr_nxt = '0;
        hi_nxt  = AW'(cnt_m1);
      end
      bal_pkg::STEP_REV_A: begin
        // read returns the old upper entry while the lower one lands there
        re    = 1'b1;
        raddr = hi_r;
        we    = 1'b1;
        waddr = hi_r;
      end
      bal_pkg::STEP_REV_B: begin
        we      = 1'b1;
        waddr   = ptr_r;
        ptr_nxt = ptr_r + AW'(1);
        hi_nxt  = hi_r - AW'(1);
        if (!sts.rev_last) begin
          re    = 1'b1;
          raddr = ptr_r + AW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    ptr_r  <= ptr_nxt;
    hi_r   <= hi_nxt;
    if (cmd.finish) begin
      out_item_r.read_value <= (cmd.step == bal_pkg::STEP_RD_FIN) ? rdata_r : '0;
      out_item_r.count      <= OW'(cnt_nxt);
      out_item_r.status     <= cmd.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== hdl/bal_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bal_ctrl
// Controller: decodes each operation and sequences the shift and swap passes.
// ----------------------------------------------------------------------------
module bal_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  bal_pkg::mode_t     mode,
  input  bal_pkg::sts_t      sts,
  output bal_pkg::cmd_t      cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_INS,
    S_INS_FIN,
    S_ERS,
    S_REV_A,
    S_REV_B
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.step   = bal_pkg::STEP_NOP;
    cmd.load   = 1'b0;
    cmd.finish = 1'b0;
    cmd.status = bal_pkg::STAT_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cmd.finish = 1'b1;
          unique case (mode)
            bal_pkg::MODE_APPEND: begin
              if (sts.full) begin
                cmd.step   = bal_pkg::STEP_REJECT;
                cmd.status = bal_pkg::STAT_FULL;
              end else begin
                cmd.step = bal_pkg::STEP_APPEND;
              end
            end
            bal_pkg::MODE_INSERT: begin
              priority if (!sts.pos_ok) begin
                cmd.step   = bal_pkg::STEP_REJECT;
                cmd.status = bal_pkg::STAT_BADPOS;
              end else if (sts.full) begin
                cmd.step   = bal_pkg::STEP_REJECT;
                cmd.status = bal_pkg::STAT_FULL;
              end else begin
                cmd.step   = bal_pkg::STEP_INS_START;
                cmd.finish = 1'b0;
                state_nxt  = S_INS;
              end
            end
            bal_pkg::MODE_POP: begin
              if (sts.empty) begin
                cmd.step   = bal_pkg::STEP_REJECT;
                cmd.status = bal_pkg::STAT_EMPTY;
              end else begin
                cmd.step = bal_pkg::STEP_POP;
              end
            end
            bal_pkg::MODE_ERASE: begin
              priority if (!sts.pos_ok) begin
                cmd.step   = bal_pkg::STEP_REJECT;
                cmd.status = bal_pkg::STAT_BADPOS;
              end else if (sts.erase_tail) begin
                // last entry: nothing to move down
                cmd.step = bal_pkg::STEP_POP;
              end else begin
                cmd.step   = bal_pkg::STEP_ERS_START;
                cmd.finish = 1'b0;
                state_nxt  = S_ERS;
              end
            end
            bal_pkg::MODE_REVERSE: begin
              if (sts.rev_short) begin
                cmd.step = bal_pkg::STEP_REJECT;
              end else begin
                cmd.step   = bal_pkg::STEP_REV_START;
                cmd.finish = 1'b0;
                state_nxt  = S_REV_A;
              end
            end
            bal_pkg::MODE_READ: begin
              if (!sts.pos_ok) begin
                cmd.step   = bal_pkg::STEP_REJECT;
                cmd.status = bal_pkg::STAT_BADPOS;
              end else begin
                cmd.step   = bal_pkg::STEP_RD_ISSUE;
                cmd.finish = 1'b0;
                state_nxt  = S_RD;
              end
            end
            bal_pkg::MODE_WRITE: begin
              if (!sts.pos_ok) begin
                cmd.step   = bal_pkg::STEP_REJECT;
                cmd.status = bal_pkg::STAT_BADPOS;
              end else begin
                cmd.step = bal_pkg::STEP_WRITE;
              end
            end
            bal_pkg::MODE_CLEAR: begin
              cmd.step = bal_pkg::STEP_CLEAR;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.step   = bal_pkg::STEP_RD_FIN;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_INS: begin
        cmd.step = bal_pkg::STEP_INS_MOVE;
        if (sts.ins_last) begin
          state_nxt = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        cmd.step   = bal_pkg::STEP_INS_FIN;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_ERS: begin
        cmd.step = bal_pkg::STEP_ERS_MOVE;
        if (sts.ers_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_REV_A: begin
        cmd.step  = bal_pkg::STEP_REV_A;
        state_nxt = S_REV_B;
      end
      S_REV_B: begin
        cmd.step = bal_pkg::STEP_REV_B;
        if (sts.rev_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_REV_A;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule
`default_nettype wire

// ===== hdl/bounded_array_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Fixed-capacity ordered list of signed words with insert/erase/reverse.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item (mode, position, value) with start high; the item
//   is taken at a clock edge where start is high and busy is low.
//   Output: every item gives one result (read_value, count, status) on
//   out_item, shown for exactly one cycle with out_valid high. The receiver
//   cannot stall; results must be taken as they come.
//   Append, pop, write, clear, rejects and erase of the last entry finish
//   straight from idle, and busy stays low for them, so those run back to
//   back. Read, insert, erase and reverse step through controller states,
//   and busy stays high while they run. Insert, erase and reverse are
//   paced by the memory, which takes one read and one write per cycle: one
//   entry moved per cycle, and each swap takes a REV_A and a REV_B step.
//   Reset clears the count and the controller; memory contents are left as
//   they are, and no entry is read before it has been written.
// ----------------------------------------------------------------------------
module bounded_array_list_engine (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  bal_pkg::in_item_t   in_item,
  output logic                out_valid,
  output bal_pkg::out_item_t  out_item
);

  bal_pkg::cmd_t cmd;
  bal_pkg::sts_t sts;

  bal_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bal_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // an accepted item either finishes next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted item neither finished nor in progress");

  a_done_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result transfer");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result transfer while still busy");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != bal_pkg::STAT_DONE) |-> (out_item.read_value == '0))
    else $error("rejected item carries a nonzero read value");

endmodule
`default_nettype wire

// ===== bench/bounded_array_list_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_tb
// Self-checking bench for the bounded array list engine. A shadow list
// inside a small scoreboard predicts the result of every operation taken by
// the engine; each result strobe is compared with the oldest prediction.
// Stimulus runs empty-list and boundary cases on a short list, then a random
// mix with random idle gaps on the command side, letting the engine run dry
// now and then.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_tb;

  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_OPS  = 116;
  localparam int SOFT_CAP    = 48;

  // Shadow of the list, with the queue of replies still owed by the engine.
  class list_tracker;
    logic signed [bal_pkg::VAL_W-1:0] words [bal_pkg::CAPACITY];
    int unsigned                      n_live;
    int unsigned                      peak;
    int                               n_errors;
    int                               n_checked;
    bal_pkg::out_item_t               replies_due[$];

    task report_miss(string msg);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function bal_pkg::out_item_t apply_op(bal_pkg::in_item_t it);
      bal_pkg::out_item_t               r;
      int unsigned                      p;
      int unsigned                      i;
      int unsigned                      j;
      logic signed [bal_pkg::VAL_W-1:0] t;
      r.read_value = '0;
      r.status     = bal_pkg::STAT_DONE;
      p            = it.position;
      case (it.mode)
        bal_pkg::MODE_APPEND: begin
          if (n_live >= bal_pkg::CAPACITY) begin
            r.status = bal_pkg::STAT_FULL;
          end else begin
            words[n_live] = it.value;
            n_live++;
          end
        end
        bal_pkg::MODE_INSERT: begin
          if (p >= n_live) begin
            r.status = bal_pkg::STAT_BADPOS;
          end else if (n_live >= bal_pkg::CAPACITY) begin
            r.status = bal_pkg::STAT_FULL;
          end else begin
            for (i = n_live; i > p; i--) words[i] = words[i-1];
            words[p] = it.value;
            n_live++;
          end
        end
        bal_pkg::MODE_POP: begin
          if (n_live == 0) r.status = bal_pkg::STAT_EMPTY;
          else n_live--;
        end
        bal_pkg::MODE_ERASE: begin
          if (p >= n_live) begin
            r.status = bal_pkg::STAT_BADPOS;
          end else begin
            for (i = p; i + 1 < n_live; i++) words[i] = words[i+1];
            n_live--;
          end
        end
        bal_pkg::MODE_REVERSE: begin
          for (i = 0; i < n_live / 2; i++) begin
            j        = n_live - 1 - i;
            t        = words[i];
            words[i] = words[j];
            words[j] = t;
          end
        end
        bal_pkg::MODE_READ: begin
          if (p >= n_live) r.status = bal_pkg::STAT_BADPOS;
          else r.read_value = words[p];
        end
        bal_pkg::MODE_WRITE: begin
          if (p >= n_live) r.status = bal_pkg::STAT_BADPOS;
          else words[p] = it.value;
        end
        default: begin
          n_live = 0;
        end
      endcase
      r.count = bal_pkg::COUNT_W'(n_live);
      return r;
    endfunction

    function void note_op(bal_pkg::in_item_t it);
      replies_due = {replies_due, apply_op(it)};
      if (n_live > peak) peak = n_live;
    endfunction

    task check_reply(bal_pkg::out_item_t got);
      bal_pkg::out_item_t want;
      if (replies_due.size() == 0) begin
        report_miss($sformatf("result with nothing outstanding (rd %0d cnt %0d st %0d)",
                              got.read_value, got.count, got.status));
      end else begin
        want = replies_due.pop_front();
        n_checked++;
        if (got.read_value !== want.read_value || got.count !== want.count ||
            got.status !== want.status)
          report_miss($sformatf("got rd %0d cnt %0d st %0d, want rd %0d cnt %0d st %0d",
                                got.read_value, got.count, got.status,
                                want.read_value, want.count, want.status));
      end
    endtask

    task close_out();
      if (replies_due.size() != 0)
        report_miss($sformatf("%0d results never arrived", replies_due.size()));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  bal_pkg::in_item_t  in_item;
  logic               out_valid;
  bal_pkg::out_item_t out_item;

  list_tracker lt;
  int          n_taken;
  int          cycles;

  bounded_array_list_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Sample both channels on the rising edge; the watchdog lives here too.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid) lt.check_reply(out_item);
    if (rst_n && start && !busy) begin
      lt.note_op(in_item);
      n_taken++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: watchdog expired after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bal_pkg::in_item_t mk(bal_pkg::mode_t m, int unsigned p,
                                           logic signed [bal_pkg::VAL_W-1:0] v);
    bal_pkg::in_item_t it;
    it.mode     = m;
    it.position = p[bal_pkg::POS_W-1:0];
    it.value    = v;
    return it;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bal_pkg::in_item_t pick_op();
    bal_pkg::in_item_t it;
    int unsigned       n;
    int unsigned       r;
    n        = lt.n_live;
    r        = $urandom_range(0, 99);
    it.value = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       it.value = 32'sh7fffffff;
        1:       it.value = 32'sh80000000;
        2:       it.value = '0;
        default: it.value = '1;
      endcase
    end
    if (r < 26)      it.mode = bal_pkg::MODE_APPEND;
    else if (r < 38) it.mode = bal_pkg::MODE_INSERT;
    else if (r < 47) it.mode = bal_pkg::MODE_POP;
    else if (r < 57) it.mode = bal_pkg::MODE_ERASE;
    else if (r < 62) it.mode = bal_pkg::MODE_REVERSE;
    else if (r < 77) it.mode = bal_pkg::MODE_READ;
    else if (r < 92) it.mode = bal_pkg::MODE_WRITE;
    else if (r < 95) it.mode = bal_pkg::MODE_CLEAR;
    else             it.mode = bal_pkg::mode_t'($urandom_range(0, 7));
    // keep the list short so the shifting ops stay quick
    if (n > SOFT_CAP && (it.mode == bal_pkg::MODE_APPEND || it.mode == bal_pkg::MODE_INSERT))
      it.mode = bal_pkg::MODE_ERASE;
    if (r >= 95 || n == 0 || $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0 && n < bal_pkg::CAPACITY)
        it.position = bal_pkg::POS_W'(n);
      else
        it.position = bal_pkg::POS_W'($urandom);
    end else begin
      it.position = bal_pkg::POS_W'($urandom_range(0, n - 1));
    end
    return it;
  endfunction

  // Drive one command after a gap and hold it until the engine takes it.
  task send(bal_pkg::in_item_t it, int gap);
    int n0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    n0 = n_taken;
    start   <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (n_taken == n0);
  endtask

  task drain();
    start <= 1'b0;
    @(negedge clk);
    while (lt.replies_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    int k;
    lt      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    n_taken = 0;
    cycles  = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty-list cases
    send(mk(bal_pkg::MODE_POP, 0, 0), 0);
    send(mk(bal_pkg::MODE_REVERSE, 0, 0), 0);
    send(mk(bal_pkg::MODE_CLEAR, 0, 0), 0);
    send(mk(bal_pkg::MODE_READ, 0, 0), 0);
    send(mk(bal_pkg::MODE_WRITE, 0, 32'sh5a5a5a5a), 0);
    send(mk(bal_pkg::MODE_ERASE, 0, 0), 0);
    send(mk(bal_pkg::MODE_INSERT, 0, 7), 0);
    // small list with extreme values, boundary positions, odd and even reverse
    send(mk(bal_pkg::MODE_APPEND, 4095, 32'sh7fffffff), 0);
    send(mk(bal_pkg::MODE_APPEND, 0, 32'sh80000000), 0);
    send(mk(bal_pkg::MODE_APPEND, 0, 0), 0);
    send(mk(bal_pkg::MODE_APPEND, 0, -1), 0);
    send(mk(bal_pkg::MODE_INSERT, 0, 12345), 0);
    send(mk(bal_pkg::MODE_INSERT, 4, -77), 0);
    send(mk(bal_pkg::MODE_INSERT, 6, 99), 0);
    send(mk(bal_pkg::MODE_READ, 4095, 0), 0);
    send(mk(bal_pkg::MODE_WRITE, 2, 32'shdeadbeef), 0);
    send(mk(bal_pkg::MODE_REVERSE, 0, 0), 0);
    send(mk(bal_pkg::MODE_ERASE, 0, 0), 0);
    send(mk(bal_pkg::MODE_REVERSE, 0, 0), 0);
    send(mk(bal_pkg::MODE_READ, 0, 0), 0);
    send(mk(bal_pkg::MODE_READ, 4, 0), 0);
    send(mk(bal_pkg::MODE_ERASE, 4, 0), 0);
    send(mk(bal_pkg::MODE_POP, 0, 0), 0);
    send(mk(bal_pkg::MODE_CLEAR, 0, 0), 0);
    drain();

    // random mix; every so often let the engine run dry
    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % 35 == 34) drain();
      send(pick_op(), (k % 50 < 10) ? 0 : idle_len());
    end

    drain();
    repeat (10) @(negedge clk);
    lt.close_out();
    $display("tb: %0d operations taken, %0d results checked, list peaked at %0d entries",
             n_taken, lt.n_checked, lt.peak);
    $display("tb: empty-list rejects, boundary positions, odd and even reverse, random mix");
    if (lt.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", lt.n_errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bal_pkg.sv
hdl/bal_dp.sv
hdl/bal_ctrl.sv
hdl/bounded_array_list_engine.sv
bench/bounded_array_list_engine_tb.sv
